// ===== hw/rtl/tkfs_pkg.sv =====
// ----------------------------------------------------------------------------
// tkfs_pkg
// Shared widths, types and helpers for the top-k frequency selector.
// ----------------------------------------------------------------------------
package tkfs_pkg;

  // Built capacity of the entry store.
  localparam int MAX_K   = 32;

  // Field widths.
  localparam int KEY_W   = 40;
  localparam int COUNT_W = 24;
  localparam int K_W     = 6;

  // Occupancy must hold MAX_K itself; an index addresses one stored entry.
  localparam int OCC_W   = $clog2(MAX_K + 1);
  localparam int IDX_W   = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  // Reset value of the retained-entry limit.
  localparam logic [K_W-1:0] K_RESET = K_W'(20);

  // Depth of the command queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // Operation codes of an input beat.
  typedef enum logic {
    OP_OFFER = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // One stored entry.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
  } entry_t;

  // One classified command as held in the queue.
  typedef struct packed {
    op_t    op;
    entry_t ent;
  } cmd_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_EMPTY
  } back_state_t;

  // Clamp the programmed limit into the range 1 .. MAX_K.
  function automatic logic [OCC_W-1:0] eff_k(input logic [K_W-1:0] k);
    logic [OCC_W-1:0] r;
    if (k == '0) begin
      r = OCC_W'(1);
    end else if (32'(k) > MAX_K) begin
      r = OCC_W'(MAX_K);
    end else begin
      r = OCC_W'(k);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/tkfs_ifs.sv =====
// ----------------------------------------------------------------------------
// tkfs_ifs
// Valid/ready channel interfaces for the offer/drain input and the results.
// ----------------------------------------------------------------------------

// Input channel: one beat is an offer or a drain command.
interface tkfs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [tkfs_pkg::KEY_W-1:0]   key;
  logic [tkfs_pkg::COUNT_W-1:0] count;

  modport source (output valid, operation, key, count, input ready);
  modport sink   (input valid, operation, key, count, output ready);
  modport mon    (input valid, ready, operation, key, count);
endinterface

// Result channel: one beat is one emitted entry.
interface tkfs_out_if;
  logic                        valid;
  logic                        ready;
  logic [tkfs_pkg::KEY_W-1:0]   out_key;
  logic [tkfs_pkg::COUNT_W-1:0] out_count;
  logic                        last;
  logic                        empty_res;

  modport source (output valid, out_key, out_count, last, empty_res, input ready);
  modport sink   (input valid, out_key, out_count, last, empty_res, output ready);
  modport mon    (input valid, ready, out_key, out_count, last, empty_res);
endinterface

// ===== hw/rtl/top_k_frequency_selector_core.sv =====
// ----------------------------------------------------------------------------
// top_k_frequency_selector_core
// Retains the k highest-count (key, count) offers and drains them in order.
// ----------------------------------------------------------------------------
// An offer beat is taken into a two-deep command queue and is applied to the
// sorted entry store, so offers sustain one beat per cycle while no drain runs.
// A drain beat emits one result per held entry, lowest count first (among
// equal counts the newer entry first), one result per cycle while the sink
// accepts, through a single output register; an empty drain gives one beat
// flagged empty_res. While a drain runs, further beats wait in the queue. The
// limit k is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle; the block itself does not enforce this. 0 acts
// as 1 and values above 32 act as 32.
module top_k_frequency_selector_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [tkfs_pkg::K_W-1:0] cfg_wdata,
  tkfs_in_if.sink                  in_ch,
  tkfs_out_if.source               out_ch
);

  tkfs_pkg::cmd_head_t head;
  logic                pop;

  // Front end: accept and queue commands.
  tkfs_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .pop   (pop),
    .head  (head)
  );

  // Back end: entry store and drain sequencer.
  tkfs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

// ===== hw/rtl/tkfs_front.sv =====
// ----------------------------------------------------------------------------
// tkfs_front
// Accepts input beats, decodes the operation and queues the commands.
// ----------------------------------------------------------------------------
module tkfs_front (
  input  logic                clk,
  input  logic                rst_n,
  tkfs_in_if.sink             in_ch,
  input  logic                pop,
  output tkfs_pkg::cmd_head_t head
);

  tkfs_pkg::cmd_t                 q_mem_r [tkfs_pkg::Q_DEPTH];
  logic [tkfs_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [tkfs_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [tkfs_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                           push;
  logic                           do_pop;
  tkfs_pkg::cmd_t                 cmd_in;

  // Room in the queue opens the input side.
  assign in_ch.ready = (cnt_r != tkfs_pkg::QCNT_W'(tkfs_pkg::Q_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign do_pop      = pop && (cnt_r != '0);

  // Classify the beat into a command.
  always_comb begin
    cmd_in.op        = tkfs_pkg::op_t'(in_ch.operation);
    cmd_in.ent.key   = in_ch.key;
    cmd_in.ent.count = in_ch.count;
  end

  // Pointer and fill-count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == tkfs_pkg::Q_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == tkfs_pkg::Q_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  // Present the oldest command to the back end.
  always_comb begin
    head.valid = (cnt_r != '0);
    head.cmd   = q_mem_r[rd_ptr_r];
  end

endmodule

// ===== hw/rtl/tkfs_back.sv =====
// ----------------------------------------------------------------------------
// tkfs_back
// Sorted entry store with ordered insert, and the drain sequencer.
// ----------------------------------------------------------------------------
module tkfs_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tkfs_pkg::K_W-1:0]      cfg_wdata,
  input  tkfs_pkg::cmd_head_t           head,
  output logic                          pop,
  tkfs_out_if.source                    out_ch
);

  // Cell 0 holds the highest-ranked entry; dropping the lowest ranks is a
  // plain cut of the occupancy.
  tkfs_pkg::entry_t                cell_r [tkfs_pkg::MAX_K];
  logic [tkfs_pkg::MAX_K-1:0]      goes_before;

  logic [tkfs_pkg::K_W-1:0]        k_r;
  logic [tkfs_pkg::OCC_W-1:0]      occ_r, occ_nxt;
  logic [tkfs_pkg::OCC_W-1:0]      k_eff;
  logic [tkfs_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  tkfs_pkg::back_state_t           state_r, state_nxt;

  logic                            out_vld_r;
  tkfs_pkg::entry_t                out_ent_r;
  logic                            out_last_r;
  logic                            out_empty_r;

  logic                            slot_free;
  logic                            do_insert;
  logic                            start_drain;
  logic                            load_ent;
  logic                            load_empty;

  assign k_eff     = tkfs_pkg::eff_k(k_r);
  assign slot_free = !out_vld_r || out_ch.ready;

  // Limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= tkfs_pkg::K_RESET;
    end else if (cfg_we) begin
      k_r <= cfg_wdata;
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tkfs_pkg::ST_IDLE: begin
        if (head.valid && head.cmd.op == tkfs_pkg::OP_DRAIN) begin
          state_nxt = (occ_r == '0) ? tkfs_pkg::ST_EMPTY : tkfs_pkg::ST_DRAIN;
        end
      end
      tkfs_pkg::ST_DRAIN: begin
        if (slot_free && idx_r == '0) begin
          state_nxt = tkfs_pkg::ST_IDLE;
        end
      end
      tkfs_pkg::ST_EMPTY: begin
        if (slot_free) begin
          state_nxt = tkfs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tkfs_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    pop         = 1'b0;
    do_insert   = 1'b0;
    start_drain = 1'b0;
    load_ent    = 1'b0;
    load_empty  = 1'b0;
    unique case (state_r)
      tkfs_pkg::ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.cmd.op == tkfs_pkg::OP_OFFER) begin
            do_insert = 1'b1;
          end else begin
            start_drain = 1'b1;
          end
        end
      end
      tkfs_pkg::ST_DRAIN: begin
        load_ent = slot_free;
      end
      tkfs_pkg::ST_EMPTY: begin
        load_empty = slot_free;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tkfs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Each cell decides locally whether the new entry lands at or before it.
  // A held entry with a count at least as large ranks above the newcomer.
  for (genvar i = 0; i < tkfs_pkg::MAX_K; i++) begin : g_cmp
    assign goes_before[i] = !((tkfs_pkg::OCC_W'(i) < occ_r) &&
                              (cell_r[i].count >= head.cmd.ent.count));
  end

  // Ordered insert: cells past the landing point shift down by one.
  for (genvar i = 0; i < tkfs_pkg::MAX_K; i++) begin : g_cell
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (do_insert && goes_before[0]) begin
          cell_r[0] <= head.cmd.ent;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (do_insert) begin
          if (goes_before[i-1]) begin
            cell_r[i] <= cell_r[i-1];
          end else if (goes_before[i]) begin
            cell_r[i] <= head.cmd.ent;
          end
        end
      end
    end
  end

  // Occupancy and drain index.
  always_comb begin
    occ_nxt = occ_r;
    idx_nxt = idx_r;
    if (do_insert) begin
      occ_nxt = (occ_r < k_eff) ? occ_r + 1'b1 : k_eff;
    end
    if (start_drain && occ_r != '0) begin
      idx_nxt = tkfs_pkg::IDX_W'(occ_r - 1'b1);
    end
    if (load_ent) begin
      if (idx_r == '0) begin
        occ_nxt = '0;
      end else begin
        idx_nxt = idx_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      idx_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      idx_r <= idx_nxt;
    end
  end

  // Output register: holds a beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_ent || load_empty) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ent) begin
      out_ent_r   <= cell_r[idx_r];
      out_last_r  <= (idx_r == '0);
      out_empty_r <= 1'b0;
    end else if (load_empty) begin
      out_ent_r   <= '0;
      out_last_r  <= 1'b1;
      out_empty_r <= 1'b1;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.out_key   = out_ent_r.key;
  assign out_ch.out_count = out_ent_r.count;
  assign out_ch.last      = out_last_r;
  assign out_ch.empty_res = out_empty_r;

endmodule

// ===== hw/rtl/tkfs_checker.sv =====
// ----------------------------------------------------------------------------
// tkfs_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tkfs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tkfs_pkg::KEY_W-1:0]   out_key,
  input logic [tkfs_pkg::COUNT_W-1:0] out_count,
  input logic                         out_last,
  input logic                         out_empty
);

  // A stalled beat stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // A stalled beat keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_key) && $stable(out_count) && $stable(out_last) && $stable(out_empty))
    else $error("result payload changed while stalled");

  // An empty drain is a single, final beat.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty |-> out_last)
    else $error("empty drain result not marked last");

  // An empty drain carries a zero entry.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty |-> (out_key == '0) && (out_count == '0))
    else $error("empty drain result carries data");

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind top_k_frequency_selector_core tkfs_checker u_tkfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_key   (out_ch.out_key),
  .out_count (out_ch.out_count),
  .out_last  (out_ch.last),
  .out_empty (out_ch.empty_res)
);
